/* rtl/core/akd_pkg.sv */
package akd_pkg;

    // decoder phase, one-hot
    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_ESC   = 6'b000010,
        PH_CSI   = 6'b000100,
        PH_SS3   = 6'b001000,
        PH_DIGIT = 6'b010000,
        PH_FTAIL = 6'b100000
    } phase_t;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_NAMED = 2'd1;
    localparam logic [1:0] KIND_BAD   = 2'd2;

    localparam logic [3:0] NK_UP        = 4'd0;
    localparam logic [3:0] NK_DOWN      = 4'd1;
    localparam logic [3:0] NK_RIGHT     = 4'd2;
    localparam logic [3:0] NK_LEFT      = 4'd3;
    localparam logic [3:0] NK_HOME      = 4'd4;
    localparam logic [3:0] NK_END       = 4'd5;
    localparam logic [3:0] NK_INSERT    = 4'd6;
    localparam logic [3:0] NK_DELETE    = 4'd7;
    localparam logic [3:0] NK_PGUP      = 4'd8;
    localparam logic [3:0] NK_PGDN      = 4'd9;
    localparam logic [3:0] NK_BACKSPACE = 4'd10;
    localparam logic [3:0] NK_FUNCTION  = 4'd11;

    localparam logic       OP_BYTE = 1'b0;
    localparam logic       OP_TICK = 1'b1;

    localparam logic [0:0] CFG_KEYPAD  = 1'd0;
    localparam logic [0:0] CFG_TIMEOUT = 1'd1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [3:0] FKEY_HIGH_BASE = 4'd9;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  digit;
        logic [3:0]  fkey;
        logic [15:0] wait_cnt;
    } dec_state_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] ch;
        logic [3:0] nk;
        logic [3:0] fk;
    } dec_result_t;

    // named key for esc [ d ~
    function automatic logic [3:0] tilde_key(input logic [2:0] d);
        logic [3:0] k;
        begin
            case (d)
                3'd2:    k = NK_INSERT;
                3'd3:    k = NK_DELETE;
                3'd4:    k = NK_END;
                3'd5:    k = NK_PGUP;
                3'd6:    k = NK_PGDN;
                default: k = NK_HOME;
            endcase
            return k;
        end
    endfunction

endpackage

/* rtl/core/akd_decode.sv */
module akd_decode (
    input  akd_pkg::dec_state_t  state,
    input  logic                 keypad_enable,
    input  logic [15:0]          timeout_ticks,
    input  logic                 opcode,
    input  logic [7:0]           byte_value,
    output akd_pkg::dec_state_t  state_next,
    output akd_pkg::dec_result_t result
);

    logic [15:0] wait_inc;
    akd_pkg::dec_state_t idle_state;

    assign wait_inc = (state.wait_cnt == 16'hFFFF) ? state.wait_cnt : state.wait_cnt + 16'd1;

    always_comb
    begin
        idle_state.phase    = akd_pkg::PH_IDLE;
        idle_state.digit    = 3'd0;
        idle_state.fkey     = 4'd0;
        idle_state.wait_cnt = 16'd0;
    end

    always_comb
    begin
        state_next = state;
        result     = '0;
        if (opcode == akd_pkg::OP_TICK)
        begin
            if (state.phase != akd_pkg::PH_IDLE)
            begin
                if (wait_inc >= timeout_ticks)
                begin
                    state_next   = idle_state;
                    result.valid = 1'b1;
                    if (state.phase == akd_pkg::PH_ESC)
                    begin
                        result.kind = akd_pkg::KIND_CHAR;
                        result.ch   = akd_pkg::CH_ESC;
                    end
                    else if (state.phase == akd_pkg::PH_FTAIL)
                    begin
                        result.kind = akd_pkg::KIND_NAMED;
                        result.nk   = akd_pkg::NK_FUNCTION;
                        result.fk   = state.fkey;
                    end
                    else
                    begin
                        result.kind = akd_pkg::KIND_BAD;
                    end
                end
                else
                begin
                    state_next.wait_cnt = wait_inc;
                end
            end
        end
        else
        begin
            state_next.wait_cnt = 16'd0;
            unique case (state.phase)
                akd_pkg::PH_IDLE:
                begin
                    if (byte_value == akd_pkg::CH_ESC && keypad_enable)
                    begin
                        state_next.phase = akd_pkg::PH_ESC;
                    end
                    else
                    begin
                        result.valid = 1'b1;
                        if (byte_value == akd_pkg::CH_DEL || byte_value == akd_pkg::CH_BS)
                        begin
                            result.kind = akd_pkg::KIND_NAMED;
                            result.nk   = akd_pkg::NK_BACKSPACE;
                        end
                        else if (byte_value == akd_pkg::CH_CR)
                        begin
                            result.kind = akd_pkg::KIND_CHAR;
                            result.ch   = akd_pkg::CH_LF;
                        end
                        else
                        begin
                            result.kind = akd_pkg::KIND_CHAR;
                            result.ch   = byte_value;
                        end
                    end
                end
                akd_pkg::PH_ESC:
                begin
                    if (byte_value == akd_pkg::CH_LBRK)
                    begin
                        state_next.phase = akd_pkg::PH_CSI;
                    end
                    else if (byte_value == akd_pkg::CH_O)
                    begin
                        state_next.phase = akd_pkg::PH_SS3;
                    end
                    else
                    begin
                        state_next   = idle_state;
                        result.valid = 1'b1;
                        result.kind  = akd_pkg::KIND_BAD;
                    end
                end
                akd_pkg::PH_CSI:
                begin
                    state_next   = idle_state;
                    result.valid = 1'b1;
                    result.kind  = akd_pkg::KIND_NAMED;
                    unique case (byte_value)
                        akd_pkg::CH_A: result.nk = akd_pkg::NK_UP;
                        akd_pkg::CH_B: result.nk = akd_pkg::NK_DOWN;
                        akd_pkg::CH_C: result.nk = akd_pkg::NK_RIGHT;
                        akd_pkg::CH_D: result.nk = akd_pkg::NK_LEFT;
                        akd_pkg::CH_H: result.nk = akd_pkg::NK_HOME;
                        akd_pkg::CH_F: result.nk = akd_pkg::NK_END;
                        default:
                        begin
                            if (byte_value >= akd_pkg::CH_1 && byte_value <= akd_pkg::CH_6)
                            begin
                                // digit held in the low bits of its ascii code
                                state_next.phase = akd_pkg::PH_DIGIT;
                                state_next.digit = byte_value[2:0];
                                result           = '0;
                            end
                            else
                            begin
                                result.kind = akd_pkg::KIND_BAD;
                            end
                        end
                    endcase
                end
                akd_pkg::PH_SS3:
                begin
                    state_next   = idle_state;
                    result.valid = 1'b1;
                    if (byte_value >= akd_pkg::CH_P && byte_value <= akd_pkg::CH_S)
                    begin
                        result.kind = akd_pkg::KIND_NAMED;
                        result.nk   = akd_pkg::NK_FUNCTION;
                        result.fk   = {2'b00, byte_value[1:0]} + 4'd1;
                    end
                    else
                    begin
                        result.kind = akd_pkg::KIND_BAD;
                    end
                end
                akd_pkg::PH_DIGIT:
                begin
                    if (byte_value == akd_pkg::CH_TILDE)
                    begin
                        state_next   = idle_state;
                        result.valid = 1'b1;
                        result.kind  = akd_pkg::KIND_NAMED;
                        result.nk    = akd_pkg::tilde_key(state.digit);
                    end
                    else if (state.digit == 3'd1 && byte_value >= akd_pkg::CH_1
                             && byte_value <= akd_pkg::CH_9)
                    begin
                        state_next.phase = akd_pkg::PH_FTAIL;
                        state_next.fkey  = byte_value[3:0];
                    end
                    else if (state.digit == 3'd2 && byte_value >= akd_pkg::CH_0
                             && byte_value <= akd_pkg::CH_4)
                    begin
                        state_next.phase = akd_pkg::PH_FTAIL;
                        state_next.fkey  = byte_value[3:0] + akd_pkg::FKEY_HIGH_BASE;
                    end
                    else
                    begin
                        state_next   = idle_state;
                        result.valid = 1'b1;
                        result.kind  = akd_pkg::KIND_BAD;
                    end
                end
                akd_pkg::PH_FTAIL:
                begin
                    // end byte taken without a check
                    state_next   = idle_state;
                    result.valid = 1'b1;
                    result.kind  = akd_pkg::KIND_NAMED;
                    result.nk    = akd_pkg::NK_FUNCTION;
                    result.fk    = state.fkey;
                end
                default:
                begin
                    state_next   = idle_state;
                    result.valid = 1'b1;
                    result.kind  = akd_pkg::KIND_BAD;
                end
            endcase
        end
    end

endmodule

/* rtl/core/ansi_key_escape_decoder.sv */
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+----------------------------------------
// input    | in        | in_valid / in_ready     | opcode, byte_value
// result   | out       | out_valid / out_ready   | key_kind, char_code, named_key, fkey_number
// config   | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one input transaction per cycle while the result side keeps up
// result valid after its input transaction passes the input register, decode logic
// and result register; ticks short of the timeout and mid-sequence bytes only move the state
// a waiting result still lets one transaction into an empty input register,
// after which in_ready stays low until the result is taken
// asynchronous active-low reset: idle phase, keypad off, timeout 100; cfg_ready always high
module ansi_key_escape_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [7:0]  byte_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  key_kind,
    output logic [7:0]  char_code,
    output logic [3:0]  named_key,
    output logic [3:0]  fkey_number,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // configuration registers
    logic        keypad_reg;
    logic [15:0] timeout_reg;

    // input register
    logic        in_vld_reg;
    logic        in_op_reg;
    logic [7:0]  in_byte_reg;

    // decoder state
    akd_pkg::dec_state_t  state_reg;
    akd_pkg::dec_state_t  state_next;
    akd_pkg::dec_result_t result;

    // result register
    logic        out_vld_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  ch_reg;
    logic [3:0]  nk_reg;
    logic [3:0]  fk_reg;

    logic        advance;

    // the decode stage moves on when the result slot is free or being emptied
    assign advance   = !out_vld_reg || out_ready;
    assign in_ready  = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    assign out_valid   = out_vld_reg;
    assign key_kind    = kind_reg;
    assign char_code   = ch_reg;
    assign named_key   = nk_reg;
    assign fkey_number = fk_reg;

    // register writes; an index beyond the list is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keypad_reg  <= 1'b0;
            timeout_reg <= akd_pkg::TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == {1'b0, akd_pkg::CFG_KEYPAD})
            begin
                keypad_reg <= cfg_data[0];
            end
            else if (cfg_index == {1'b0, akd_pkg::CFG_TIMEOUT})
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_op_reg   <= opcode;
            in_byte_reg <= byte_value;
        end
    end

    akd_decode u_decode (
        .state         (state_reg),
        .keypad_enable (keypad_reg),
        .timeout_ticks (timeout_reg),
        .opcode        (in_op_reg),
        .byte_value    (in_byte_reg),
        .state_next    (state_next),
        .result        (result)
    );

    // decoder state advances once per transaction leaving the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase    <= akd_pkg::PH_IDLE;
            state_reg.digit    <= 3'd0;
            state_reg.fkey     <= 4'd0;
            state_reg.wait_cnt <= 16'd0;
        end
        else if (advance && in_vld_reg)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= in_vld_reg && result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_vld_reg && result.valid)
        begin
            kind_reg <= result.kind;
            ch_reg   <= result.ch;
            nk_reg   <= result.nk;
            fk_reg   <= result.fk;
        end
    end

endmodule
